FILE: rtl/gpe_pkg.sv
`timescale 1ns / 1ps

package gpe_pkg;

    localparam int IndexW  = 8;
    localparam int LevelW  = 6;
    localparam int ColorW  = 3 * LevelW;
    localparam int WeightW = 9;
    localparam int SumW    = 14;
    localparam int NumChan = 3;

    typedef logic [LevelW-1:0]  level_t;
    typedef logic [ColorW-1:0]  color_t;
    typedef logic [WeightW-1:0] weight_t;
    typedef logic [SumW-1:0]    sum_t;

    // Gradient mode codes; the spare code behaves as the two-stop ramp.
    typedef enum logic [1:0] {
        MODE_RAMP   = 2'd0,
        MODE_MIRROR = 2'd1,
        MODE_CYCLE  = 2'd2
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_FIRST  = 2'd1,
        REG_MIDDLE = 2'd2,
        REG_LAST   = 2'd3
    } cfg_reg_t;

    // Which configured colour feeds a weight.
    typedef enum logic [1:0] {
        SEL_FIRST  = 2'd0,
        SEL_MIDDLE = 2'd1,
        SEL_LAST   = 2'd2
    } sel_t;

    // Divisor applied to the weighted sum.
    typedef enum logic [1:0] {
        DIV_255 = 2'd0,
        DIV_128 = 2'd1,
        DIV_85  = 2'd2
    } div_t;

    // Segment decode for one palette index, shared by all three channels.
    typedef struct packed {
        weight_t weight_a;
        weight_t weight_b;
        sel_t    sel_a;
        sel_t    sel_b;
        div_t    div_kind;
    } seg_t;

    localparam color_t FirstReset  = '0;
    localparam color_t MiddleReset = '0;
    localparam color_t LastReset   = '1;

    // Pick one channel level of the selected colour.
    function automatic level_t pick_level(sel_t sel, level_t f, level_t m, level_t l);
        level_t r;
        unique case (sel)
            SEL_FIRST:  r = f;
            SEL_MIDDLE: r = m;
            SEL_LAST:   r = l;
            default:    r = f;
        endcase
        return r;
    endfunction

    // Divide the weighted sum by its divisor. Division by 85 is done as
    // three times the sum over 255; the quotient by 255 uses the add-shift
    // form that is exact while the quotient stays within six bits.
    function automatic level_t divide_sum(sum_t sum, div_t kind);
        logic [15:0] t;
        logic [15:0] q;
        level_t      r;
        unique case (kind)
            DIV_85:  t = {2'b00, sum} + {1'b0, sum, 1'b0};
            default: t = {2'b00, sum};
        endcase
        q = (t + (t >> 8) + 16'd1) >> 8;
        unique case (kind)
            DIV_128: r = sum[LevelW+6:7];
            default: r = q[LevelW-1:0];
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/gradient_palette_entry.sv
`timescale 1ns / 1ps

// Gradient palette entry generator. Each input word is a palette index and
// produces one output word with the entry's 6-bit red, green and blue levels,
// interpolated between the configured colours in the selected gradient mode;
// index zero is always black. One index is taken every clock unless output stall
// has filled every stage; its levels pass through an input register, a register
// holding the weighted sums of the three channels, and the output register that
// applies the divisor. Output stall backs up through these stages, so up to three
// words can be held while the output is stalled. Configuration registers
// take effect on the next word and must be written while no word is in flight.
module gradient_palette_entry
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [1:0]                 cfg_index,
    input  logic [gpe_pkg::ColorW-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [gpe_pkg::IndexW-1:0] entry_index,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [gpe_pkg::LevelW-1:0] red_level,
    output logic [gpe_pkg::LevelW-1:0] green_level,
    output logic [gpe_pkg::LevelW-1:0] blue_level
);
    import gpe_pkg::*;

    logic [1:0]  mode_reg;
    color_t      first_reg;
    color_t      middle_reg;
    color_t      last_reg;

    logic        s1_valid_reg;
    logic [IndexW-1:0] s1_index_reg;
    logic        s2_valid_reg;
    sum_t        s2_sum_reg [NumChan];
    div_t        s2_div_reg;
    logic        out_valid_reg;
    level_t      level_reg [NumChan];

    logic        out_ready;
    logic        s2_ready;
    logic        s1_ready;
    seg_t        seg;
    sum_t        sum_next [NumChan];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RAMP;
            first_reg  <= FirstReset;
            middle_reg <= MiddleReset;
            last_reg   <= LastReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MODE:   mode_reg   <= cfg_data[1:0];
                REG_FIRST:  first_reg  <= cfg_data;
                REG_MIDDLE: middle_reg <= cfg_data;
                REG_LAST:   last_reg   <= cfg_data;
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    // Each stage advances when it is empty or the next stage can take its word.
    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;

    // Stage 1: input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_index_reg <= entry_index;
        end
    end

    gpe_segment u_segment
    (
        .entry_index (s1_index_reg),
        .mode        (mode_reg),
        .seg         (seg)
    );

    // Weighted sum of two colour levels for each channel.
    for (genvar k = 0; k < NumChan; k++)
    begin : g_chan
        localparam int Lsb = (NumChan - 1 - k) * LevelW;
        level_t       lvl_a;
        level_t       lvl_b;
        logic [14:0]  prod_a;
        logic [14:0]  prod_b;
        logic [14:0]  sum_w;

        assign lvl_a  = pick_level(seg.sel_a, first_reg[Lsb +: LevelW],
                                   middle_reg[Lsb +: LevelW], last_reg[Lsb +: LevelW]);
        assign lvl_b  = pick_level(seg.sel_b, first_reg[Lsb +: LevelW],
                                   middle_reg[Lsb +: LevelW], last_reg[Lsb +: LevelW]);
        assign prod_a = {6'b0, seg.weight_a} * {9'b0, lvl_a};
        assign prod_b = {6'b0, seg.weight_b} * {9'b0, lvl_b};
        assign sum_w  = prod_a + prod_b;
        assign sum_next[k] = sum_w[SumW-1:0];
    end

    // Stage 2: weighted sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_sum_reg <= sum_next;
            s2_div_reg <= seg.div_kind;
        end
    end

    // Stage 3: divide and hold the output word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            for (int k = 0; k < NumChan; k++)
            begin
                level_reg[k] <= divide_sum(s2_sum_reg[k], s2_div_reg);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_level   = level_reg[0];
    assign green_level = level_reg[1];
    assign blue_level  = level_reg[2];

    // An accepted word always lands in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted word did not reach the input register");

    // Input is held back only when every stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // Index zero yields zero sums on every channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready && s1_index_reg == '0) |=>
        (s2_sum_reg[0] == '0 && s2_sum_reg[1] == '0 && s2_sum_reg[2] == '0))
        else $error("index zero gave a nonzero sum");

endmodule

FILE: rtl/gpe_segment.sv
`timescale 1ns / 1ps

module gpe_segment
(
    input  logic [gpe_pkg::IndexW-1:0] entry_index,
    input  logic [1:0]                 mode,
    output gpe_pkg::seg_t              seg
);
    import gpe_pkg::*;

    weight_t idx;

    assign idx = {1'b0, entry_index};

    // Choose the two weights and colours of the segment the index falls in.
    // Index zero gets zero weights, which yields black in every mode.
    always_comb
    begin
        seg.weight_a = '0;
        seg.weight_b = '0;
        seg.sel_a    = SEL_FIRST;
        seg.sel_b    = SEL_LAST;
        seg.div_kind = DIV_255;
        unique case (mode)
            MODE_MIRROR:
            begin
                seg.div_kind = DIV_128;
                priority if (entry_index == '0)
                begin
                    seg.weight_a = '0;
                end
                else if (idx <= 9'd128)
                begin
                    seg.weight_a = idx;
                    seg.weight_b = 9'd128 - idx;
                    seg.sel_a    = SEL_LAST;
                    seg.sel_b    = SEL_FIRST;
                end
                else
                begin
                    seg.weight_a = idx - 9'd127;
                    seg.weight_b = 9'd255 - idx;
                    seg.sel_a    = SEL_FIRST;
                    seg.sel_b    = SEL_LAST;
                end
            end
            MODE_CYCLE:
            begin
                seg.div_kind = DIV_85;
                priority if (entry_index == '0)
                begin
                    seg.weight_a = '0;
                end
                else if (idx <= 9'd85)
                begin
                    seg.weight_a = idx;
                    seg.weight_b = 9'd86 - idx;
                    seg.sel_a    = SEL_MIDDLE;
                    seg.sel_b    = SEL_FIRST;
                end
                else if (idx <= 9'd170)
                begin
                    seg.weight_a = idx - 9'd85;
                    seg.weight_b = 9'd171 - idx;
                    seg.sel_a    = SEL_LAST;
                    seg.sel_b    = SEL_MIDDLE;
                end
                else
                begin
                    seg.weight_a = idx - 9'd170;
                    seg.weight_b = 9'd256 - idx;
                    seg.sel_a    = SEL_FIRST;
                    seg.sel_b    = SEL_LAST;
                end
            end
            default:
            begin
                seg.div_kind = DIV_255;
                if (entry_index != '0)
                begin
                    seg.weight_a = idx;
                    seg.weight_b = 9'd256 - idx;
                end
            end
        endcase
    end

endmodule

FILE: sim/gradient_palette_entry_test.sv
`timescale 1ns / 1ps

module gradient_palette_entry_test;

    import gpe_pkg::*;

    // One expected palette entry.
    typedef struct {
        logic [IndexW-1:0] index;
        level_t            red;
        level_t            green;
        level_t            blue;
    } palette_levels_t;

    localparam int LongHold = 200;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic [1:0]        cfg_index = REG_MODE;
    color_t            cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [IndexW-1:0] entry_index = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    level_t            red_level;
    level_t            green_level;
    level_t            blue_level;

    // Shadow copy of the configuration registers.
    logic [1:0] palette_mode = MODE_RAMP;
    color_t     first_color = FirstReset;
    color_t     middle_color = MiddleReset;
    color_t     last_color = LastReset;

    logic [IndexW-1:0] pending_indexes[$];
    palette_levels_t   expected_levels[$];

    int  mismatch_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_count = 0;
    int  hold_requests = 0;
    int  holds_done = 0;
    bit  quiet = 1'b0;
    bit  in_taken = 1'b0;

    gradient_palette_entry i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .entry_index (entry_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Interpolates one channel between the configured colour levels.
    function automatic level_t gradient_level(logic [IndexW-1:0] idx, level_t f, level_t m,
                                              level_t l);
        int unsigned i;
        int unsigned v;
        i = idx;
        if (i == 0)
        begin
            return '0;
        end
        case (palette_mode)
            MODE_MIRROR:
            begin
                if (i <= 128)
                    v = (i * l + (128 - i) * f) / 128;
                else
                    v = ((i - 127) * f + (255 - i) * l) / 128;
            end
            MODE_CYCLE:
            begin
                if (i <= 85)
                    v = (i * m + (86 - i) * f) / 85;
                else if (i <= 170)
                    v = ((i - 85) * l + (171 - i) * m) / 85;
                else
                    v = ((i - 170) * f + (256 - i) * l) / 85;
            end
            // The spare mode code falls back to the two-stop ramp.
            default:
            begin
                v = (i * f + (256 - i) * l) / 255;
            end
        endcase
        return level_t'(v);
    endfunction

    function automatic palette_levels_t predict_entry(logic [IndexW-1:0] idx);
        palette_levels_t e;
        e.index = idx;
        e.red   = gradient_level(idx, first_color[17:12], middle_color[17:12], last_color[17:12]);
        e.green = gradient_level(idx, first_color[11:6], middle_color[11:6], last_color[11:6]);
        e.blue  = gradient_level(idx, first_color[5:0], middle_color[5:0], last_color[5:0]);
        return e;
    endfunction

    // Mostly short gaps, a few long ones, none while the quiet flag is set.
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Indexes cluster around segment boundaries a quarter of the time.
    function automatic logic [IndexW-1:0] next_index();
        if ($urandom_range(0, 3) != 0)
            return IndexW'($urandom_range(0, 255));
        case ($urandom_range(0, 12))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd84;
            3:       return 8'd85;
            4:       return 8'd86;
            5:       return 8'd127;
            6:       return 8'd128;
            7:       return 8'd129;
            8:       return 8'd169;
            9:       return 8'd170;
            10:      return 8'd171;
            11:      return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Sender: presents queued indexes, holding each word until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_indexes.size() != 0)
            begin
                in_valid    <= 1'b1;
                entry_index <= pending_indexes.pop_front();
                gap_left    <= next_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_requests != holds_done)
        begin
            if (hold_count < LongHold)
            begin
                out_stall  <= 1'b1;
                hold_count <= hold_count + 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                hold_count <= 0;
                holds_done <= holds_done + 1;
            end
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            int r;
            r = $urandom_range(0, 99);
            if (quiet || r < 70)
            begin
                out_stall <= 1'b0;
            end
            else if (r < 95)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(15, 50);
            end
        end
    end

    // Monitor: predicts each accepted index and checks each accepted word.
    always @(posedge clk)
    begin
        palette_levels_t want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                expected_levels.push_back(predict_entry(entry_index));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_levels.size() == 0)
                begin
                    report_mismatch("output word with no entry outstanding");
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (red_level !== want.red)
                        report_mismatch($sformatf("index %0d red %0d, expected %0d",
                                                  want.index, red_level, want.red));
                    if (green_level !== want.green)
                        report_mismatch($sformatf("index %0d green %0d, expected %0d",
                                                  want.index, green_level, want.green));
                    if (blue_level !== want.blue)
                        report_mismatch($sformatf("index %0d blue %0d, expected %0d",
                                                  want.index, blue_level, want.blue));
                end
            end
        end
    end

    // Writes one register and updates the shadow copy with it.
    task automatic write_register(cfg_reg_t idx, color_t data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_MODE:   palette_mode = data[1:0];
            REG_FIRST:  first_color = data;
            REG_MIDDLE: middle_color = data;
            REG_LAST:   last_color = data;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // The mode word carries random upper bits, which the block must ignore.
    task automatic program_gradient(logic [1:0] mode, color_t f, color_t m, color_t l);
        write_register(REG_MODE, {16'($urandom_range(0, 65535)), mode});
        write_register(REG_FIRST, f);
        write_register(REG_MIDDLE, m);
        write_register(REG_LAST, l);
    endtask

    // Waits until every queued index has gone through and every word is back.
    // The queues and the input valid are only stable at the rising edge.
    task automatic wait_palette_idle();
        while (pending_indexes.size() != 0 || in_valid || expected_levels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        color_t f;
        color_t m;
        color_t l;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Reset colours: ramp falls from white toward black, index zero stays black.
        pending_indexes.push_back(8'd0);
        pending_indexes.push_back(8'd1);
        pending_indexes.push_back(8'd128);
        pending_indexes.push_back(8'd255);
        wait_palette_idle();

        // Mirrored ramp across its fold, from full-scale first to black last.
        program_gradient(MODE_MIRROR, '1, 18'h0AB55, '0);
        pending_indexes.push_back(8'd0);
        pending_indexes.push_back(8'd1);
        pending_indexes.push_back(8'd127);
        pending_indexes.push_back(8'd128);
        pending_indexes.push_back(8'd129);
        pending_indexes.push_back(8'd255);
        wait_palette_idle();

        // Three-stop cycle at each segment boundary.
        program_gradient(MODE_CYCLE, '1, 18'h15A2A, '0);
        pending_indexes.push_back(8'd0);
        pending_indexes.push_back(8'd1);
        pending_indexes.push_back(8'd85);
        pending_indexes.push_back(8'd86);
        pending_indexes.push_back(8'd170);
        pending_indexes.push_back(8'd171);
        pending_indexes.push_back(8'd255);
        wait_palette_idle();

        // The unused mode code acts as the plain ramp.
        program_gradient(2'd3, '1, '1, '0);
        pending_indexes.push_back(8'd0);
        pending_indexes.push_back(8'd1);
        pending_indexes.push_back(8'd255);
        wait_palette_idle();

        // Random phases, each with its own configuration and pacing.
        for (int p = 0; p < 12; p++)
        begin
            f = color_t'($urandom_range(0, 262143));
            m = color_t'($urandom_range(0, 262143));
            l = color_t'($urandom_range(0, 262143));
            if (p == 0)
            begin
                f = '0;
                m = '0;
                l = '0;
            end
            else if (p == 1)
            begin
                f = '1;
                m = '1;
                l = '1;
            end
            else if (p == 2)
            begin
                f = '1;
                m = '0;
                l = '1;
            end
            program_gradient(2'(p % 4), f, m, l);
            quiet = (p == 5 || p == 6 || p == 9);
            // Hold the output back while the sender keeps offering words.
            if (p == 6)
            begin
                hold_requests = hold_requests + 1;
            end
            for (int n = 0; n < 120; n++)
            begin
                pending_indexes.push_back(next_index());
            end
            wait_palette_idle();
        end

        repeat (10) @(negedge clk);
        if (expected_levels.size() != 0)
        begin
            report_mismatch("entries still outstanding at the end");
        end
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: gradient_palette_entry.f
rtl/gpe_pkg.sv
rtl/gpe_segment.sv
rtl/gradient_palette_entry.sv
sim/gradient_palette_entry_test.sv
